/* rtl/adrc_pkg.sv */
// adrc_pkg: types, constants and elaboration-time helpers for the compressor core
// no dependencies; imported by adrc_mul, audio_dynamic_range_compressor_core and the testbench
package adrc_pkg;

   localparam int MUL_W  = 32;
   localparam int PROD_W = 64;

   localparam logic signed [15:0] DB_FLOOR_Q88    = -16'sd30720;
   localparam logic [31:0]        DB_PER_OCTAVE_K = 32'd394566;
   localparam logic [31:0]        OCTAVE_PER_DB_K = 32'd2786635;
   localparam logic [16:0]        INV_RATIO_MAX   = 17'd65536;
   localparam logic [30:0]        ONE_Q30         = 31'h4000_0000;

   localparam logic [2:0] CSR_ENABLE        = 3'd0;
   localparam logic [2:0] CSR_THRESHOLD_DB  = 3'd1;
   localparam logic [2:0] CSR_INVERSE_RATIO = 3'd2;
   localparam logic [2:0] CSR_ATTACK_COEFF  = 3'd3;
   localparam logic [2:0] CSR_RELEASE_COEFF = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOG_MUL,
      ST_LOG_UPD,
      ST_DB_MUL,
      ST_DB_UPD,
      ST_ENV_MUL,
      ST_ENV_UPD,
      ST_TGT_MUL,
      ST_TGT_UPD,
      ST_EXP_MUL,
      ST_EXP_UPD,
      ST_POW_MUL,
      ST_POW_UPD,
      ST_SCALE_MUL,
      ST_SCALE_UPD,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [MUL_W-1:0] a;
      logic [MUL_W-1:0] b;
   } mul_req_type;

   // floor integer square root, used only to build constants
   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = v_in;
      r = 64'd0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (b > v) b = b >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (b != 64'd0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   // 2^(2^-k) in Q1.30 by repeated square roots of 2
   function automatic logic [30:0] pow_rom_entry(input int k);
      logic [63:0] r;
      r = isqrt64(64'd2 << 60);
      for (int j = 2; j <= k; j++) begin
         r = isqrt64(r << 30);
      end
      return r[30:0];
   endfunction

endpackage

/* rtl/adrc_mul.sv */
// adrc_mul: shared 32x32 unsigned multiplier with registered product
// depends on adrc_pkg
module adrc_mul (
   input  logic                      clock,
   input  adrc_pkg::mul_req_type     mul_req,
   output logic [adrc_pkg::PROD_W-1:0] mul_prod
);
   import adrc_pkg::*;

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   assign prod_in = mul_req.a * mul_req.b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_prod = prod_ff;

endmodule

/* rtl/audio_dynamic_range_compressor_core.sv */
// audio_dynamic_range_compressor_core: feedforward compressor with dB envelope
// depends on adrc_pkg and adrc_mul
//
// One sample is taken at a time. The sample's magnitude is converted to a dB
// level (log2 by 16 squaring steps), a one-pole envelope follows that level,
// and above the threshold the sample is scaled by 2^(gain in octaves), built
// from 16 constant factors. Every product goes through one shared 32x32
// multiplier whose output is registered. A disabled sample goes straight to
// the output; a zero sample skips the log, and a zero sample or one whose
// envelope stays at or below the threshold skips the gain steps. When
// compressing, the exponent takes one extra multiply per set fraction bit.
// The input is stalled while a sample is at work; a finished result sits in
// the output register and the next sample is taken while it waits.
// Configuration writes land at once and belong in idle time.
module audio_dynamic_range_compressor_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic signed [23:0] req_sample_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [23:0] rsp_sample_out,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [16:0] csr_write_data
);
   import adrc_pkg::*;

   // sequencer
   state_type state_ff, state_in;

   // configuration registers
   logic               enable_ff, enable_in;
   logic signed [15:0] thr_ff, thr_in;
   logic [16:0]        ir_ff, ir_in;
   logic [15:0]        att_ff, att_in;
   logic [15:0]        rel_ff, rel_in;

   // working registers
   logic signed [23:0] x_ff, x_in;
   logic [23:0]        m_ff, m_in;
   logic [30:0]        y_ff, y_in;
   logic signed [5:0]  lint_ff, lint_in;
   logic [15:0]        lfrac_ff, lfrac_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic signed [15:0] lvl_ff, lvl_in;
   logic signed [15:0] env_ff, env_in;
   logic signed [16:0] tgt_ff, tgt_in;
   logic signed [25:0] e_ff, e_in;
   logic [30:0]        acc_ff, acc_in;
   logic signed [23:0] res_ff, res_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [23:0] rsp_data_ff, rsp_data_in;

   // shared multiplier
   mul_req_type        mul_req;
   logic [PROD_W-1:0]  mul_prod;

   adrc_mul u_mul (
      .clock    (clock),
      .mul_req  (mul_req),
      .mul_prod (mul_prod)
   );

   // constant factor table 2^(2^-k), k = 1..16
   logic [30:0] rom_w [0:15];
   for (genvar j = 0; j < 16; j++) begin : g_rom
      localparam logic [30:0] ROM_K = pow_rom_entry(j + 1);
      assign rom_w[j] = ROM_K;
   end

   // ---------------- combinational helpers ----------------
   logic               accept;
   logic               out_free;
   logic signed [24:0] req_ext;
   logic [24:0]        req_neg;
   logic [23:0]        req_mag;
   logic [4:0]         lead_p;
   logic [30:0]        y_start;
   logic signed [5:0]  lint_start;
   logic [31:0]        y_sq;
   logic signed [21:0] l_val;
   logic               l_neg;
   logic [21:0]        l_mag;
   logic [63:0]        rnd24, rnd16, rnd30;
   logic signed [17:0] t_db;
   logic signed [15:0] lvl_db;
   logic               env_rise;
   logic [15:0]        coef;
   logic signed [16:0] d_env;
   logic [16:0]        d_mag;
   logic signed [17:0] r_env;
   logic signed [17:0] env_new;
   logic signed [16:0] dt;
   logic [16:0]        ir_cl;
   logic signed [16:0] tgt_new;
   logic signed [17:0] rel_db;
   logic [17:0]        rel_mag;
   logic signed [25:0] e_new;
   logic               f_bit;
   logic signed [9:0]  n_oct;
   logic signed [10:0] n_cl;
   logic signed [10:0] s_wide;
   logic [6:0]         s_amt;
   logic [71:0]        p72;
   logic [71:0]        p_shift;
   logic [55:0]        mag;
   logic signed [23:0] sat_out;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      req_ext = {req_sample_in[23], req_sample_in};
      req_neg = 25'(-req_ext);
      req_mag = req_sample_in[23] ? req_neg[23:0] : $unsigned(req_sample_in);
      lead_p  = 5'd0;
      for (int i = 0; i < 24; i++) begin
         if (req_mag[i]) lead_p = 5'(i);
      end
   end

   assign y_start    = 31'({7'd0, req_mag} << (5'd30 - lead_p));
   assign lint_start = $signed({1'b0, lead_p}) - 6'sd23;

   // log squaring step
   assign y_sq = mul_prod[61:30];

   // level in dB
   assign l_val = {lint_ff, lfrac_ff};
   assign l_neg = l_val[21];
   assign l_mag = l_neg ? 22'(-l_val) : $unsigned(l_val);
   assign rnd24 = (mul_prod + (64'd1 << 23)) >> 24;
   assign rnd16 = (mul_prod + (64'd1 << 15)) >> 16;
   assign rnd30 = (mul_prod + (64'd1 << 29)) >> 30;
   assign t_db  = l_neg ? -$signed({1'b0, rnd24[16:0]}) : $signed({1'b0, rnd24[16:0]});
   assign lvl_db = (t_db < 18'sd0 - 18'sd30720) ? DB_FLOOR_Q88 : t_db[15:0];

   // envelope smoothing toward the level
   assign env_rise = lvl_ff > env_ff;
   assign coef     = env_rise ? att_ff : rel_ff;
   assign d_env    = {env_ff[15], env_ff} - {lvl_ff[15], lvl_ff};
   assign d_mag    = d_env[16] ? 17'(-d_env) : $unsigned(d_env);
   assign r_env    = d_env[16] ? -$signed({1'b0, rnd16[16:0]}) : $signed({1'b0, rnd16[16:0]});
   assign env_new  = {{2{lvl_ff[15]}}, lvl_ff} + r_env;

   // target level above threshold
   assign dt      = {env_ff[15], env_ff} - {thr_ff[15], thr_ff};
   assign ir_cl   = (ir_ff > INV_RATIO_MAX) ? INV_RATIO_MAX : ir_ff;
   assign tgt_new = {thr_ff[15], thr_ff} + $signed({1'b0, rnd16[15:0]});

   // gain exponent in octaves
   assign rel_db  = {tgt_ff[16], tgt_ff} - {{2{lvl_ff[15]}}, lvl_ff};
   assign rel_mag = rel_db[17] ? 18'(-rel_db) : $unsigned(rel_db);
   assign e_new   = rel_db[17] ? -$signed({1'b0, rnd16[24:0]}) : $signed({1'b0, rnd16[24:0]});
   assign f_bit   = e_ff[4'd15 - cnt_ff];

   // final scaling, rounding half up, saturation
   always_comb begin
      n_oct = e_ff[25:16];
      if (n_oct > 10'sd29) begin
         n_cl = 11'sd29;
      end else if (n_oct < -10'sd40) begin
         n_cl = -11'sd40;
      end else begin
         n_cl = {n_oct[9], n_oct};
      end
      s_wide  = 11'sd30 - n_cl;
      s_amt   = s_wide[6:0];
      p72     = {17'd0, mul_prod[54:0]};
      p_shift = p72 >> s_amt;
      mag     = p_shift[55:0] + {55'd0, p72[s_amt - 7'd1]};
      if (x_ff[23]) begin
         if (mag > 56'd8388608) sat_out = -24'sd8388608;
         else sat_out = 24'(-$signed({1'b0, mag[23:0]}));
      end else begin
         if (mag > 56'd8388607) sat_out = 24'sd8388607;
         else sat_out = $signed(mag[23:0]);
      end
   end

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!enable_ff) state_in = ST_OUT;
               else if (req_mag == 24'd0) state_in = ST_ENV_MUL;
               else state_in = ST_LOG_MUL;
            end
         end
         ST_LOG_MUL: state_in = ST_LOG_UPD;
         ST_LOG_UPD: state_in = (cnt_ff == 4'd0) ? ST_DB_MUL : ST_LOG_MUL;
         ST_DB_MUL:  state_in = ST_DB_UPD;
         ST_DB_UPD:  state_in = ST_ENV_MUL;
         ST_ENV_MUL: state_in = ST_ENV_UPD;
         ST_ENV_UPD: begin
            if ($signed(env_new[15:0]) <= thr_ff || m_ff == 24'd0) state_in = ST_OUT;
            else state_in = ST_TGT_MUL;
         end
         ST_TGT_MUL: state_in = ST_TGT_UPD;
         ST_TGT_UPD: state_in = ST_EXP_MUL;
         ST_EXP_MUL: state_in = ST_EXP_UPD;
         ST_EXP_UPD: state_in = ST_POW_MUL;
         ST_POW_MUL: begin
            if (f_bit) state_in = ST_POW_UPD;
            else if (cnt_ff == 4'd15) state_in = ST_SCALE_MUL;
         end
         ST_POW_UPD:   state_in = (cnt_ff == 4'd15) ? ST_SCALE_MUL : ST_POW_MUL;
         ST_SCALE_MUL: state_in = ST_SCALE_UPD;
         ST_SCALE_UPD: state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- sequencer outputs ----------------
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      mul_req.a = 32'd0;
      mul_req.b = 32'd0;
      case (state_ff)
         ST_LOG_MUL: begin
            mul_req.a = {1'b0, y_ff};
            mul_req.b = {1'b0, y_ff};
         end
         ST_DB_MUL: begin
            mul_req.a = {10'd0, l_mag};
            mul_req.b = DB_PER_OCTAVE_K;
         end
         ST_ENV_MUL: begin
            mul_req.a = {15'd0, d_mag};
            mul_req.b = {16'd0, coef};
         end
         ST_TGT_MUL: begin
            mul_req.a = {15'd0, $unsigned(dt)};
            mul_req.b = {15'd0, ir_cl};
         end
         ST_EXP_MUL: begin
            mul_req.a = {14'd0, rel_mag};
            mul_req.b = OCTAVE_PER_DB_K;
         end
         ST_POW_MUL: begin
            mul_req.a = {1'b0, acc_ff};
            mul_req.b = {1'b0, rom_w[cnt_ff]};
         end
         ST_SCALE_MUL: begin
            mul_req.a = {8'd0, m_ff};
            mul_req.b = {1'b0, acc_ff};
         end
         default: begin
            mul_req.a = 32'd0;
            mul_req.b = 32'd0;
         end
      endcase
   end

   // ---------------- datapath next values ----------------
   always_comb begin
      x_in     = x_ff;
      m_in     = m_ff;
      y_in     = y_ff;
      lint_in  = lint_ff;
      lfrac_in = lfrac_ff;
      cnt_in   = cnt_ff;
      lvl_in   = lvl_ff;
      env_in   = env_ff;
      tgt_in   = tgt_ff;
      e_in     = e_ff;
      acc_in   = acc_ff;
      res_in   = res_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x_in     = req_sample_in;
               m_in     = req_mag;
               y_in     = y_start;
               lint_in  = lint_start;
               lfrac_in = 16'd0;
               cnt_in   = 4'd15;
               lvl_in   = DB_FLOOR_Q88;
               res_in   = req_sample_in;
            end
         end
         ST_LOG_UPD: begin
            if (y_sq[31]) begin
               lfrac_in[cnt_ff] = 1'b1;
               y_in = y_sq[31:1];
            end else begin
               y_in = y_sq[30:0];
            end
            cnt_in = cnt_ff - 4'd1;
         end
         ST_DB_UPD: lvl_in = lvl_db;
         ST_ENV_UPD: begin
            env_in = env_new[15:0];
            res_in = x_ff;
         end
         ST_TGT_UPD: tgt_in = tgt_new;
         ST_EXP_UPD: begin
            e_in   = e_new;
            acc_in = ONE_Q30;
            cnt_in = 4'd0;
         end
         ST_POW_MUL: begin
            if (!f_bit) cnt_in = cnt_ff + 4'd1;
         end
         ST_POW_UPD: begin
            acc_in = rnd30[30:0];
            cnt_in = cnt_ff + 4'd1;
         end
         ST_SCALE_UPD: res_in = sat_out;
         default: begin
            x_in = x_ff;
         end
      endcase
   end

   // configuration writes
   always_comb begin
      enable_in = enable_ff;
      thr_in    = thr_ff;
      ir_in     = ir_ff;
      att_in    = att_ff;
      rel_in    = rel_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ENABLE:        enable_in = csr_write_data[0];
            CSR_THRESHOLD_DB:  thr_in    = $signed(csr_write_data[15:0]);
            CSR_INVERSE_RATIO: ir_in     = csr_write_data;
            CSR_ATTACK_COEFF:  att_in    = csr_write_data[15:0];
            CSR_RELEASE_COEFF: rel_in    = csr_write_data[15:0];
            default:           enable_in = enable_ff;
         endcase
      end
   end

   // output register: loads when free, drops when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (state_ff == ST_OUT && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         env_ff       <= 16'sd0;
         enable_ff    <= 1'b1;
         thr_ff       <= -16'sd5120;
         ir_ff        <= 17'd16384;
         att_ff       <= 16'd65399;
         rel_ff       <= 16'd65522;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         env_ff       <= env_in;
         enable_ff    <= enable_in;
         thr_ff       <= thr_in;
         ir_ff        <= ir_in;
         att_ff       <= att_in;
         rel_ff       <= rel_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      m_ff        <= m_in;
      y_ff        <= y_in;
      lint_ff     <= lint_in;
      lfrac_ff    <= lfrac_in;
      cnt_ff      <= cnt_in;
      lvl_ff      <= lvl_in;
      tgt_ff      <= tgt_in;
      e_ff        <= e_in;
      acc_ff      <= acc_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

endmodule

/* test/tb_audio_dynamic_range_compressor_core.sv */
// tb_audio_dynamic_range_compressor_core: self-checking bench for the compressor core
// depends on adrc_pkg and audio_dynamic_range_compressor_core
`timescale 1ns / 1ps

module tb_audio_dynamic_range_compressor_core;
   import adrc_pkg::*;

   localparam int N_RANDOM    = 1450;
   localparam int CYCLE_LIMIT = 2_000_000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic signed [23:0] req_sample_in;
   logic        rsp_valid;
   logic        rsp_stall;
   logic signed [23:0] rsp_sample_out;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [16:0] csr_write_data;

   audio_dynamic_range_compressor_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_sample_in(req_sample_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_sample_out(rsp_sample_out),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // predictor copy of configuration and envelope
   logic               cmp_enable;
   logic signed [15:0] cmp_threshold;
   logic [16:0]        cmp_inv_ratio;
   logic [15:0]        cmp_attack;
   logic [15:0]        cmp_release;
   logic signed [15:0] cmp_envelope;
   logic [63:0]        octave_factor [1:16];

   logic signed [23:0] pending_samples [$];
   logic signed [23:0] expected_outputs [$];
   int  error_count;
   int  cycle_count;
   bit  hold_sender;     // sender pauses while set
   bit  quiet_phase;     // no idling near the end
   int  send_gap;
   int  recv_gap;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
      logic [63:0] v, r, b;
      v = v_in;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // signed shift right by s with ties away from zero
   function automatic longint round_away(input longint v, input int s);
      longint half;
      half = longint'(1) << (s - 1);
      if (v >= 0) return (v + half) >>> s;
      return -(((-v) + half) >>> s);
   endfunction

   // magnitude to dB level, Q8.8, floored
   function automatic int level_of(input longint m);
      int p;
      longint unsigned y;
      longint l, t;
      if (m == 0) return DB_FLOOR_Q88;
      p = 23;
      while (((m >> p) & 1) == 0) p--;
      y = longint'(m) << (30 - p);
      l = longint'(p - 23) * 65536;
      for (int i = 15; i >= 0; i--) begin
         y = (y * y) >> 30;
         if (y >= (64'd1 << 31)) begin
            l += longint'(1) << i;
            y = y >> 1;
         end
      end
      t = round_away(l * longint'(DB_PER_OCTAVE_K), 24);
      if (t < DB_FLOOR_Q88) t = DB_FLOOR_Q88;
      return int'(t);
   endfunction

   function automatic int smooth_toward(input int lvl, input int env, input longint c);
      return lvl + int'(round_away((longint'(env) - lvl) * c, 16));
   endfunction

   // advance the envelope and return the expected output sample
   function automatic logic signed [23:0] compress_sample(input logic signed [23:0] x);
      longint m, rel, e, n, f, res;
      longint unsigned acc, mag;
      int lvl, tgt, s;
      longint ir;
      if (!cmp_enable) return x;
      m = (x < 0) ? -longint'(x) : longint'(x);
      lvl = level_of(m);
      if (lvl > cmp_envelope) cmp_envelope = 16'(smooth_toward(lvl, cmp_envelope, cmp_attack));
      else cmp_envelope = 16'(smooth_toward(lvl, cmp_envelope, cmp_release));
      if (cmp_envelope <= cmp_threshold || m == 0) return x;
      ir = (cmp_inv_ratio > 17'd65536) ? 65536 : longint'(cmp_inv_ratio);
      tgt = cmp_threshold
            + int'(round_away((longint'(cmp_envelope) - cmp_threshold) * ir, 16));
      rel = longint'(tgt) - lvl;
      e = round_away(rel * longint'(OCTAVE_PER_DB_K), 16);
      if (e >= 0) n = e / 65536;
      else n = -(((-e) + 65535) / 65536);
      f = e - n * 65536;
      acc = 64'd1 << 30;
      for (int k = 1; k <= 16; k++)
         if ((f >> (16 - k)) & 1) acc = (acc * octave_factor[k] + (64'd1 << 29)) >> 30;
      if (n > 29) n = 29;
      if (n < -40) n = -40;
      s = 30 - int'(n);
      mag = (longint'(m) * acc + (64'd1 << (s - 1))) >> s;
      if (x < 0) res = (mag > 8388608) ? -8388608 : -longint'(mag);
      else res = (mag > 8388607) ? 8388607 : longint'(mag);
      return res[23:0];
   endfunction

   task automatic report_mismatch(input string what);
      $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // register write in idle time, mirrored into the predictor
   task automatic write_register(input logic [2:0] idx, input logic [16:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_ENABLE:        cmp_enable    = value[0];
         CSR_THRESHOLD_DB:  cmp_threshold = value[15:0];
         CSR_INVERSE_RATIO: cmp_inv_ratio = value;
         CSR_ATTACK_COEFF:  cmp_attack    = value[15:0];
         CSR_RELEASE_COEFF: cmp_release   = value[15:0];
         default: ;
      endcase
   endtask

   // wait until every queued transaction is sent and answered
   task automatic drain_all();
      while (pending_samples.size() != 0 || expected_outputs.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic logic signed [23:0] random_sample();
      int kind;
      logic [23:0] v;
      kind = $urandom_range(0, 9);
      v = 24'($urandom);
      case (kind)
         0: v = v >> $urandom_range(1, 23);          // quiet
         1: v = $signed(v) >>> $urandom_range(1, 23); // quiet, either sign
         2: v = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
         default: ;
      endcase
      return v;
   endfunction

   task automatic queue_random(input int count);
      repeat (count) pending_samples.push_back(random_sample());
   endtask

   // driver: transaction goes out when valid and no stall
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (req_valid && !req_stall) begin
         expected_outputs.push_back(compress_sample(req_sample_in));
         void'(pending_samples.pop_front());
         if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            req_valid <= 1'b0;
            send_gap  <= $urandom_range(1, 10);
         end else if (pending_samples.size() != 0 && !hold_sender) begin
            req_valid     <= 1'b1;
            req_sample_in <= pending_samples[0];
         end else begin
            req_valid <= 1'b0;
         end
      end else if (!req_valid) begin
         if (send_gap != 0) begin
            send_gap <= send_gap - 1;
         end else if (pending_samples.size() != 0 && !hold_sender) begin
            req_valid     <= 1'b1;
            req_sample_in <= pending_samples[0];
         end
      end
   end

   // monitor and receiver stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_gap  <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_outputs.size() == 0) begin
               report_mismatch($sformatf("unexpected sample_out %0d", rsp_sample_out));
            end else if (rsp_sample_out !== expected_outputs[0]) begin
               report_mismatch($sformatf("sample_out %0d, expected %0d",
                                         rsp_sample_out, expected_outputs[0]));
               void'(expected_outputs.pop_front());
            end else begin
               void'(expected_outputs.pop_front());
            end
         end
         if (recv_gap != 0) begin
            recv_gap <= recv_gap - 1;
            rsp_stall <= (recv_gap != 1);
         end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
            recv_gap  <= $urandom_range(1, 10);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      logic [63:0] r;
      cycle_count = 0;
      error_count = 0;
      hold_sender = 1'b0;
      quiet_phase = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample_in = '0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_ENABLE;
      csr_write_data = '0;
      r = int_sqrt(64'd2 << 60);
      octave_factor[1] = r;
      for (int k = 2; k <= 16; k++) octave_factor[k] = int_sqrt(octave_factor[k - 1] << 30);
      cmp_enable = 1'b1;
      cmp_threshold = -16'sd5120;
      cmp_inv_ratio = 17'd16384;
      cmp_attack = 16'd65399;
      cmp_release = 16'd65522;
      cmp_envelope = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, extremes and zero
      pending_samples.push_back(24'sh000000);
      pending_samples.push_back(24'sh7FFFFF);
      pending_samples.push_back(24'sh800000);
      pending_samples.push_back(24'sh800001);
      pending_samples.push_back(24'sh000001);
      pending_samples.push_back(24'shFFFFFF);
      pending_samples.push_back(24'sh400000);
      pending_samples.push_back(24'shC00000);
      pending_samples.push_back(24'sh000000);
      pending_samples.push_back(24'sh555555);
      pending_samples.push_back(24'shAAAAAA);
      drain_all();

      // pass through while disabled
      write_register(CSR_ENABLE, 17'd0);
      pending_samples.push_back(24'sh7FFFFF);
      pending_samples.push_back(24'sh800000);
      pending_samples.push_back(24'sh123456);
      drain_all();

      // limiter with instant attack and release, low threshold
      write_register(CSR_ENABLE, 17'd1);
      write_register(CSR_THRESHOLD_DB, 17'h18800);     // -30720
      write_register(CSR_INVERSE_RATIO, 17'd0);
      write_register(CSR_ATTACK_COEFF, 17'd0);
      write_register(CSR_RELEASE_COEFF, 17'd0);
      pending_samples.push_back(24'sh7FFFFF);
      pending_samples.push_back(24'sh800000);
      pending_samples.push_back(24'sh000001);
      pending_samples.push_back(24'sh000000);
      drain_all();

      // ratio over full scale, slowest coefficients, threshold zero
      write_register(CSR_INVERSE_RATIO, 17'h1FFFF);
      write_register(CSR_ATTACK_COEFF, 17'd65535);
      write_register(CSR_RELEASE_COEFF, 17'd65535);
      write_register(CSR_THRESHOLD_DB, 17'd0);
      pending_samples.push_back(24'sh7FFFFF);
      pending_samples.push_back(24'sh000010);
      drain_all();

      // random phases across settings
      for (int ph = 0; ph < 8; ph++) begin
         write_register(CSR_ENABLE, (ph == 3) ? 17'd0 : 17'd1);
         write_register(CSR_THRESHOLD_DB,
                        17'(-$urandom_range(0, 30720)) & 17'h0FFFF);
         write_register(CSR_INVERSE_RATIO,
                        (ph == 5) ? 17'd65536 : 17'($urandom_range(0, 70000)));
         write_register(CSR_ATTACK_COEFF,
                        (ph == 1) ? 17'd0 : 17'($urandom_range(0, 65535)));
         write_register(CSR_RELEASE_COEFF,
                        (ph == 2) ? 17'd65535 : 17'($urandom_range(0, 65535)));
         if (ph == 4) begin
            // hold the sender back until every result is in
            hold_sender = 1'b1;
            queue_random(N_RANDOM / 16);
            repeat (50) @(posedge clock);
            while (expected_outputs.size() != 0) @(posedge clock);
            hold_sender = 1'b0;
            queue_random(N_RANDOM / 16);
         end else begin
            queue_random(N_RANDOM / 8);
         end
         if (ph == 7) quiet_phase = 1'b1;
         drain_all();
      end

      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/adrc_pkg.sv
rtl/adrc_mul.sv
rtl/audio_dynamic_range_compressor_core.sv
test/tb_audio_dynamic_range_compressor_core.sv
